// ===== design/pcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants for the prefix-code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

    localparam int SYMBOL_COUNT = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int BYTE_BITS    = 8;
    localparam int PEND_W       = BYTE_BITS - 1;
    localparam int PCNT_W       = $clog2(BYTE_BITS);
    localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
    localparam int ACC_W        = MAX_CODE_LEN + PEND_W;
    localparam int TOT_W        = $clog2(ACC_W + 1);
    localparam int OUT_DEPTH    = ACC_W / BYTE_BITS;
    localparam int OCNT_W       = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef struct packed {
        logic [MAX_CODE_LEN-1:0] bits;
        logic [LEN_W-1:0]        len;
    } code_entry_t;

endpackage

// ===== design/prefix_code_bit_packer_core.sv =====
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_core
// Table-driven prefix-code encoder with an MSB-first byte packer.
//
//   channel | dir | handshake         | payload
//   s_      | in  | s_valid / s_ready | action, symbol, code_value, code_length
//   m_      | out | m_valid / m_ready | packed_byte, last_of_run
//
// An item is taken every cycle while each item yields at most one byte and the
// result port takes it; an item that yields more bytes (up to 4) holds the byte
// queue until they drain through the one-byte result port. The code table read is registered.
// Reset clears the table valid bits, the pending bits and the byte queue at once.
// A stalled result port stalls the input only once the queue cannot be refilled.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_core
    import pcbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_symbol,
    input  logic [31:0] s_code_value,
    input  logic [5:0]  s_code_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_packed_byte,
    output logic        m_last_of_run
);

    code_entry_t             code_mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] entry_valid_reg;
    code_entry_t             rd_entry_reg;
    logic                    rd_hit_reg;

    logic                    st1_valid_reg;
    action_t                 st1_action_reg;

    logic [PEND_W-1:0]       pending_bits_reg, pending_bits_next;
    logic [PCNT_W-1:0]       pending_count_reg, pending_count_next;

    logic [7:0]              out_byte_reg [OUT_DEPTH];
    logic [7:0]              out_byte_next [OUT_DEPTH];
    logic [OCNT_W-1:0]       out_count_reg, out_count_next;

    logic                    s_accept;
    logic                    m_accept;
    logic                    q_free;
    logic                    st1_adv;
    logic                    in_range;
    logic [ADDR_W-1:0]       addr;
    logic [5:0]              sat_len;
    logic [31:0]             masked_value;
    code_entry_t             wr_entry;

    logic [LEN_W-1:0]        clen;
    logic [MAX_CODE_LEN-1:0] cbits;
    logic [ACC_W-1:0]        acc;
    logic [ACC_W-1:0]        aligned;
    logic [TOT_W-1:0]        total;
    logic [OCNT_W-1:0]       enc_count;
    logic [7:0]              flush_byte;

    assign s_accept = s_valid && s_ready;
    assign m_accept = m_valid && m_ready;
    assign m_valid  = (out_count_reg != '0);
    assign q_free   = (out_count_reg == '0) ||
                      ((out_count_reg == OCNT_W'(1)) && m_ready);
    assign st1_adv  = st1_valid_reg && q_free;
    assign s_ready  = !st1_valid_reg || q_free;

    assign m_packed_byte = out_byte_reg[0];
    assign m_last_of_run = (out_count_reg == OCNT_W'(1));

    // table write side
    assign in_range     = ({1'b0, s_symbol} < 9'(SYMBOL_COUNT));
    assign addr         = s_symbol[ADDR_W-1:0];
    assign sat_len      = (s_code_length > 6'(MAX_CODE_LEN)) ? 6'(MAX_CODE_LEN)
                                                              : s_code_length;
    assign masked_value = s_code_value & ~({32{1'b1}} << sat_len);
    assign wr_entry     = '{bits: MAX_CODE_LEN'(masked_value), len: LEN_W'(sat_len)};

    always_ff @(posedge aclk) begin
        if (s_accept && (action_t'(s_action) == ACT_LOAD) && in_range) begin
            code_mem[addr] <= wr_entry;
        end
        if (s_accept) begin
            rd_entry_reg <= code_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
            rd_hit_reg      <= 1'b0;
            st1_valid_reg   <= 1'b0;
            st1_action_reg  <= ACT_NONE;
        end else begin
            if (s_accept && (action_t'(s_action) == ACT_LOAD) && in_range) begin
                entry_valid_reg[addr] <= 1'b1;
            end
            if (s_accept) begin
                rd_hit_reg     <= in_range && entry_valid_reg[addr];
                st1_action_reg <= action_t'(s_action);
                st1_valid_reg  <= 1'b1;
            end else if (st1_adv) begin
                st1_valid_reg  <= 1'b0;
            end
        end
    end

    // pack
    assign clen    = rd_hit_reg ? rd_entry_reg.len  : '0;
    assign cbits   = rd_hit_reg ? rd_entry_reg.bits : '0;
    assign acc     = (ACC_W'(pending_bits_reg) << clen) | ACC_W'(cbits);
    assign total   = TOT_W'(pending_count_reg) + TOT_W'(clen);
    assign aligned = acc << (TOT_W'(ACC_W) - total);
    assign enc_count  = OCNT_W'(total >> PCNT_W);
    assign flush_byte = 8'(pending_bits_reg) << (4'(BYTE_BITS) - 4'(pending_count_reg));

    always_comb begin
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        out_count_next     = out_count_reg;
        for (int k = 0; k < OUT_DEPTH; k++) begin
            out_byte_next[k] = out_byte_reg[k];
        end
        if (m_accept) begin
            out_count_next = out_count_reg - OCNT_W'(1);
            for (int k = 0; k < OUT_DEPTH - 1; k++) begin
                out_byte_next[k] = out_byte_reg[k + 1];
            end
        end
        if (st1_adv) begin
            case (st1_action_reg)
                ACT_ENCODE: begin
                    for (int k = 0; k < OUT_DEPTH; k++) begin
                        out_byte_next[k] = aligned[ACC_W - 1 - BYTE_BITS * k -: BYTE_BITS];
                    end
                    out_count_next     = enc_count;
                    pending_count_next = total[PCNT_W-1:0];
                    pending_bits_next  = acc[PEND_W-1:0] &
                                         ~({PEND_W{1'b1}} << total[PCNT_W-1:0]);
                end
                ACT_FLUSH: begin
                    if (pending_count_reg != '0) begin
                        out_byte_next[0] = flush_byte;
                        out_count_next   = OCNT_W'(1);
                    end else begin
                        out_count_next   = '0;
                    end
                    pending_bits_next  = '0;
                    pending_count_next = '0;
                end
                default: begin
                    out_count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < OUT_DEPTH; k++) begin
            out_byte_reg[k] <= out_byte_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
            out_count_reg     <= '0;
        end else begin
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            out_count_reg     <= out_count_next;
        end
    end

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_count_reg <= OCNT_W'(OUT_DEPTH))
        else $error("byte queue count out of range");

    a_pending_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !st1_adv |=> $stable(pending_count_reg) && $stable(pending_bits_reg))
        else $error("pending bits changed without an item");

    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_adv && (st1_action_reg == ACT_FLUSH) |=> pending_count_reg == '0)
        else $error("flush left bits pending");

    a_bytes_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_adv && (st1_action_reg == ACT_ENCODE) && (enc_count != '0) |=> m_valid)
        else $error("encoded bytes not presented");

endmodule

// ===== test/packed_byte_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_byte_checker
// Watches both channels of the prefix-code bit packer. It keeps its own copy
// of the code table and the partial byte, predicts the packed bytes of every
// accepted item, and compares each delivered byte with the oldest prediction.
// ----------------------------------------------------------------------------
module packed_byte_checker
    import pcbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_symbol,
    input  logic [31:0] s_code_value,
    input  logic [5:0]  s_code_length,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_packed_byte,
    input  logic        m_last_of_run,
    output int          fail_count,
    output int          bytes_outstanding,
    output int          bytes_checked
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } packed_byte_t;

    logic [MAX_CODE_LEN-1:0] code_bits [SYMBOL_COUNT];
    logic [5:0]              code_len  [SYMBOL_COUNT];
    logic [PEND_W-1:0]       pend_bits;
    logic [PCNT_W-1:0]       pend_count;
    packed_byte_t            expected_bytes [$];

    function automatic logic [63:0] low_bits(input int unsigned n);
        return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    task automatic clear_codes();
        for (int i = 0; i < SYMBOL_COUNT; i++) begin
            code_bits[i] = '0;
            code_len[i]  = '0;
        end
        pend_bits  = '0;
        pend_count = '0;
        expected_bytes.delete();
    endtask

    task automatic predict_bytes(input action_t act, input logic [7:0] sym,
                                 input logic [31:0] value, input logic [5:0] len);
        logic [63:0]  acc;
        logic [15:0]  padded;
        logic [5:0]   kept_len;
        int unsigned  clen;
        int unsigned  total;
        packed_byte_t b;
        case (act)
            ACT_LOAD: begin
                if (sym < SYMBOL_COUNT) begin
                    kept_len = (len > MAX_CODE_LEN) ? 6'(MAX_CODE_LEN) : len;
                    code_bits[sym] = MAX_CODE_LEN'(64'(value) & low_bits(kept_len));
                    code_len[sym]  = kept_len;
                end
            end
            ACT_ENCODE: begin
                if (sym < SYMBOL_COUNT) begin
                    clen  = code_len[sym];
                    acc   = (64'(pend_bits) << clen) | (64'(code_bits[sym]) & low_bits(clen));
                    total = pend_count + clen;
                    while (total >= BYTE_BITS) begin
                        total  -= BYTE_BITS;
                        b.data = 8'(acc >> total);
                        b.last = (total < BYTE_BITS);
                        expected_bytes.insert(expected_bytes.size(), b);
                    end
                    pend_bits  = PEND_W'(acc & low_bits(total));
                    pend_count = PCNT_W'(total);
                end
            end
            ACT_FLUSH: begin
                if (pend_count != 0) begin
                    padded = 16'(pend_bits) << (BYTE_BITS - pend_count);
                    b.data = padded[7:0];
                    b.last = 1'b1;
                    expected_bytes.insert(expected_bytes.size(), b);
                    pend_bits  = '0;
                    pend_count = '0;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        packed_byte_t want;
        if (!aresetn) begin
            clear_codes();
        end else begin
            if (s_valid && s_ready)
                predict_bytes(action_t'(s_action), s_symbol, s_code_value, s_code_length);
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte %02h (last %0b)", m_packed_byte, m_last_of_run);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (m_packed_byte !== want.data) begin
                        $error("packed_byte: expected %02h, got %02h", want.data, m_packed_byte);
                        fail_count++;
                    end
                    if (m_last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, m_last_of_run);
                        fail_count++;
                    end
                end
            end
        end
        bytes_outstanding = expected_bytes.size();
    end

endmodule

// ===== test/prefix_code_bit_packer_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_core_test
// Drives load, encode, flush and unused-action items into the bit packer with
// random gaps on the input and random stalls on the byte output. A directed
// opening covers the edge cases; random traffic over a small symbol pool
// follows. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_core_test
    import pcbp_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 70;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [7:0]  s_symbol;
    logic [31:0] s_code_value;
    logic [5:0]  s_code_length;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_packed_byte;
    logic        m_last_of_run;

    int          fail_count;
    int          bytes_outstanding;
    int          bytes_checked;
    int          cycle_count;
    int          load_count;
    int          encode_count;
    int          flush_count;
    int          other_count;
    int unsigned stall_left;
    bit          quiet;
    logic [7:0]  symbol_pool [16];

    prefix_code_bit_packer_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_symbol      (s_symbol),
        .s_code_value  (s_code_value),
        .s_code_length (s_code_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_packed_byte (m_packed_byte),
        .m_last_of_run (m_last_of_run)
    );

    packed_byte_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_symbol          (s_symbol),
        .s_code_value      (s_code_value),
        .s_code_length     (s_code_length),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_packed_byte     (m_packed_byte),
        .m_last_of_run     (m_last_of_run),
        .fail_count        (fail_count),
        .bytes_outstanding (bytes_outstanding),
        .bytes_checked     (bytes_checked)
    );

    initial begin
        aclk = 1'b0;
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
            stall_left = idle_len();
        end
    end

    task automatic send_item(input action_t act, input logic [7:0] sym,
                             input logic [31:0] value, input logic [5:0] len);
        int unsigned gap;
        gap = idle_len();
        if (gap != 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_action      = act;
        s_symbol      = sym;
        s_code_value  = value;
        s_code_length = len;
        s_valid       = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        case (act)
            ACT_LOAD:   load_count++;
            ACT_ENCODE: encode_count++;
            ACT_FLUSH:  flush_count++;
            default:    other_count++;
        endcase
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (bytes_outstanding != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return symbol_pool[$urandom_range(0, 15)];
    endfunction

    function automatic logic [5:0] pick_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 6'd0;
        if (r < 70)
            return 6'($urandom_range(1, 12));
        if (r < 90)
            return 6'($urandom_range(13, 32));
        return 6'($urandom_range(33, 63));
    endfunction

    initial begin
        int unsigned r;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_action      = ACT_NONE;
        s_symbol      = '0;
        s_code_value  = '0;
        s_code_length = '0;
        quiet         = 1'b0;
        load_count    = 0;
        encode_count  = 0;
        flush_count   = 0;
        other_count   = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // cleared table, empty flush, unused action
        send_item(ACT_ENCODE, 8'd5, 32'hFFFF_FFFF, 6'd63);
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(ACT_NONE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        // longest code, overlong length, stray high bits, short codes
        send_item(ACT_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
        send_item(ACT_LOAD, 8'd255, 32'h8000_0001, 6'd63);
        send_item(ACT_LOAD, 8'd1, 32'hFFFF_FFFD, 6'd3);
        send_item(ACT_LOAD, 8'd2, 32'h0, 6'd1);
        send_item(ACT_LOAD, 8'd3, 32'h5A5A_5AA5, 6'd8);
        send_item(ACT_LOAD, 8'd4, 32'hDEAD_BEEF, 6'd0);
        send_item(ACT_LOAD, 8'd7, 32'h0000_0055, 6'd7);
        send_item(ACT_ENCODE, 8'd1, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd2, 32'h0, 6'd0);
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd4, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd7, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd2, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd7, 32'h0, 6'd0);
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);

        symbol_pool[0]  = 8'd0;
        symbol_pool[15] = 8'd255;
        for (int i = 1; i < 15; i++)
            symbol_pool[i] = 8'($urandom);
        for (int i = 0; i < 16; i++)
            send_item(ACT_LOAD, symbol_pool[i], $urandom, pick_length());

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= 55 && i < 70);
            if (i == 40)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 20)
                send_item(ACT_LOAD, pick_symbol(), $urandom, pick_length());
            else if (r < 85)
                send_item(ACT_ENCODE, pick_symbol(), $urandom, 6'($urandom));
            else if (r < 95)
                send_item(ACT_FLUSH, 8'($urandom), $urandom, 6'($urandom));
            else
                send_item(ACT_NONE, 8'($urandom), $urandom, 6'($urandom));
        end
        quiet = 1'b0;
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);

        wait_drained();
        repeat (20) @(negedge aclk);

        $display("items: %0d load, %0d encode, %0d flush, %0d unused action",
                 load_count, encode_count, flush_count, other_count);
        $display("packed bytes compared: %0d", bytes_checked);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
